// ===== src/nearest_palette_color_l1_macros.svh =====
// assertion macros used by the port level checker file
`ifndef NEAREST_PALETTE_COLOR_L1_MACROS_SVH
`define NEAREST_PALETTE_COLOR_L1_MACROS_SVH

// property checked on every clock edge, suspended while reset is low
`define NPC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define NPC_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/npc_pkg.sv =====
// shared constants, types and helpers of the nearest palette color search
package npc_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int ADDR_SLOTS    = 256;
    localparam int NUM_CELLS     = (PALETTE_DEPTH < ADDR_SLOTS) ? PALETTE_DEPTH : ADDR_SLOTS;
    // span from the accept edge to the edge that ends the strobe cycle: the cell row plus the result register
    localparam int LATENCY       = NUM_CELLS + 1;

    localparam int CH_W   = 8;
    localparam int SLOT_W = 8;
    localparam int SIZE_W = 9;
    localparam int DIST_W = 10;

    typedef enum logic {
        FUNC_LOAD  = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    // one transaction moving down the cell row, with the best match so far
    typedef struct packed {
        logic              valid;
        t_func             func;
        logic [SLOT_W-1:0] index;
        logic [CH_W-1:0]   blue;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   red;
        logic              have;
        logic [DIST_W-1:0] distance;
        logic [SLOT_W-1:0] slot;
        logic [CH_W-1:0]   best_blue;
        logic [CH_W-1:0]   best_green;
        logic [CH_W-1:0]   best_red;
    } t_stream;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== src/nearest_palette_color_l1.sv =====
// top level: row of palette cells that finds the nearest color by L1 distance
//
//  channel   handshake                        payload
//  input     start high and busy low          i_func, i_entry_index, i_blue/green/red
//  config    i_cfg_valid and o_cfg_ready      i_cfg_palette_size
//  result    o_result_strobe, one cycle       o_found, o_match_*
//
// one transaction enters per clock; busy stays low and config is always ready
// a query result passes each cell's stream register in turn and then the result register
// before it reaches the ports
// loads travel the same row and write their cell on arrival, so order is kept
// synchronous active low reset empties the row; palette entries keep no reset value
module nearest_palette_color_l1 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_func,
    input  logic [npc_pkg::SLOT_W-1:0]   i_entry_index,
    input  logic [npc_pkg::CH_W-1:0]     i_blue,
    input  logic [npc_pkg::CH_W-1:0]     i_green,
    input  logic [npc_pkg::CH_W-1:0]     i_red,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [npc_pkg::SIZE_W-1:0]   i_cfg_palette_size,
    output logic                         o_result_strobe,
    output logic                         o_found,
    output logic [npc_pkg::CH_W-1:0]     o_match_blue,
    output logic [npc_pkg::CH_W-1:0]     o_match_green,
    output logic [npc_pkg::CH_W-1:0]     o_match_red,
    output logic [npc_pkg::DIST_W-1:0]   o_match_distance,
    output logic [npc_pkg::SLOT_W-1:0]   o_match_slot
);

    npc_pkg::t_stream           w_link [0:npc_pkg::NUM_CELLS];
    logic [npc_pkg::SIZE_W-1:0] r_size;
    logic                       r_strobe;
    logic                       r_found;
    logic [npc_pkg::CH_W-1:0]   r_blue;
    logic [npc_pkg::CH_W-1:0]   r_green;
    logic [npc_pkg::CH_W-1:0]   r_red;
    logic [npc_pkg::DIST_W-1:0] r_dist;
    logic [npc_pkg::SLOT_W-1:0] r_slot;
    logic                       n_strobe;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_size <= i_cfg_palette_size;
        end
    end

    always_comb begin
        w_link[0].valid      = start && !busy;
        w_link[0].func       = npc_pkg::t_func'(i_func);
        w_link[0].index      = i_entry_index;
        w_link[0].blue       = i_blue;
        w_link[0].green      = i_green;
        w_link[0].red        = i_red;
        w_link[0].have       = 1'b0;
        w_link[0].distance   = '0;
        w_link[0].slot       = '0;
        w_link[0].best_blue  = '0;
        w_link[0].best_green = '0;
        w_link[0].best_red   = '0;
    end

    for (genvar g = 0; g < npc_pkg::NUM_CELLS; g++) begin : g_cell
        npc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cell_id (npc_pkg::SLOT_W'(g)),
            .i_size    (r_size),
            .i_stream  (w_link[g]),
            .o_stream  (w_link[g+1])
        );
    end

    assign n_strobe = w_link[npc_pkg::NUM_CELLS].valid
                   && (w_link[npc_pkg::NUM_CELLS].func == npc_pkg::FUNC_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
        end
    end

    // best fields start at zero, so an empty palette reports all zeros
    always_ff @(posedge i_clk) begin
        if (n_strobe) begin
            r_found <= w_link[npc_pkg::NUM_CELLS].have;
            r_blue  <= w_link[npc_pkg::NUM_CELLS].best_blue;
            r_green <= w_link[npc_pkg::NUM_CELLS].best_green;
            r_red   <= w_link[npc_pkg::NUM_CELLS].best_red;
            r_dist  <= w_link[npc_pkg::NUM_CELLS].distance;
            r_slot  <= w_link[npc_pkg::NUM_CELLS].slot;
        end
    end

    assign o_result_strobe  = r_strobe;
    assign o_found          = r_found;
    assign o_match_blue     = r_blue;
    assign o_match_green    = r_green;
    assign o_match_red      = r_red;
    assign o_match_distance = r_dist;
    assign o_match_slot     = r_slot;

endmodule

// ===== src/npc_cell.sv =====
// one palette cell: holds an entry, applies loads and updates the running best match
module npc_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [npc_pkg::SLOT_W-1:0]   i_cell_id,
    input  logic [npc_pkg::SIZE_W-1:0]   i_size,
    input  npc_pkg::t_stream             i_stream,
    output npc_pkg::t_stream             o_stream
);

    logic [npc_pkg::CH_W-1:0]   r_blue;
    logic [npc_pkg::CH_W-1:0]   r_green;
    logic [npc_pkg::CH_W-1:0]   r_red;
    npc_pkg::t_stream           r_stream;
    npc_pkg::t_stream           n_stream;
    logic [npc_pkg::DIST_W-1:0] w_dist;
    logic                       w_load;
    logic                       w_live;
    logic                       w_take;

    assign w_dist = npc_pkg::DIST_W'(npc_pkg::abs_diff(r_blue, i_stream.blue))
                  + npc_pkg::DIST_W'(npc_pkg::abs_diff(r_green, i_stream.green))
                  + npc_pkg::DIST_W'(npc_pkg::abs_diff(r_red, i_stream.red));

    assign w_load = i_stream.valid && (i_stream.func == npc_pkg::FUNC_LOAD)
                 && (i_stream.index == i_cell_id);
    assign w_live = {1'b0, i_cell_id} < i_size;
    // strict compare keeps the lowest slot on ties
    assign w_take = i_stream.valid && (i_stream.func == npc_pkg::FUNC_QUERY) && w_live
                 && (!i_stream.have || (w_dist < i_stream.distance));

    always_comb begin
        n_stream = i_stream;
        if (w_take) begin
            n_stream.have       = 1'b1;
            n_stream.distance   = w_dist;
            n_stream.slot       = i_cell_id;
            n_stream.best_blue  = r_blue;
            n_stream.best_green = r_green;
            n_stream.best_red   = r_red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_blue  <= i_stream.blue;
            r_green <= i_stream.green;
            r_red   <= i_stream.red;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream.valid <= 1'b0;
        end else begin
            r_stream <= n_stream;
        end
    end

    assign o_stream = r_stream;

endmodule

// ===== src/npc_checker.sv =====
// port level checker for the nearest palette color block, with its bind
`include "nearest_palette_color_l1_macros.svh"

module npc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         i_func,
    input  logic                         o_result_strobe,
    input  logic                         o_found,
    input  logic [npc_pkg::CH_W-1:0]     o_match_blue,
    input  logic [npc_pkg::CH_W-1:0]     o_match_green,
    input  logic [npc_pkg::CH_W-1:0]     o_match_red,
    input  logic [npc_pkg::DIST_W-1:0]   o_match_distance,
    input  logic [npc_pkg::SLOT_W-1:0]   o_match_slot
);

    localparam int RUN_W = $clog2(npc_pkg::LATENCY + 1);

    // consecutive edges with reset released, saturating at the latency
    logic [RUN_W-1:0] r_run;
    logic             w_warm;
    logic             w_query;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (r_run != RUN_W'(npc_pkg::LATENCY)) begin
            r_run <= r_run + 1'b1;
        end
    end

    assign w_warm  = (r_run == RUN_W'(npc_pkg::LATENCY));
    assign w_query = start && !busy && i_func;

    `NPC_ASSERT_RUN(a_query_gives_result,
        w_warm && $past(w_query, npc_pkg::LATENCY) |-> o_result_strobe,
        "accepted query did not produce a result")

    `NPC_ASSERT_RUN(a_result_has_query,
        w_warm && o_result_strobe |-> $past(w_query, npc_pkg::LATENCY),
        "result without a matching query transaction")

    `NPC_ASSERT_ALL(a_reset_quiet,
        !i_rst_n |=> !o_result_strobe,
        "result strobe right after reset")

    `NPC_ASSERT_RUN(a_empty_zero,
        o_result_strobe && !o_found |-> (o_match_blue == '0) && (o_match_green == '0)
            && (o_match_red == '0) && (o_match_distance == '0) && (o_match_slot == '0),
        "not-found result carries nonzero fields")

endmodule

bind nearest_palette_color_l1 npc_checker u_npc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_func           (i_func),
    .o_result_strobe  (o_result_strobe),
    .o_found          (o_found),
    .o_match_blue     (o_match_blue),
    .o_match_green    (o_match_green),
    .o_match_red      (o_match_red),
    .o_match_distance (o_match_distance),
    .o_match_slot     (o_match_slot)
);
